@@ hdl/cmc_pkg.sv @@
// Shared constants, types and helpers for the calibrated millisecond counter.
package cmc_pkg;

    localparam int TIME_W  = 64;
    localparam int COUNT_W = 32;
    localparam int RATIO_W = 32;
    localparam int STEP_W  = 32;
    localparam int TENTH_W = 29;
    localparam int SHIFT_W = 6;
    localparam int PROD_W  = 52;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 264;

    localparam logic [TIME_W-1:0]  NS_PER_MS   = 64'd1000000;
    localparam logic [19:0]        NS_PER_MS20 = 20'd1000000;
    localparam logic [TIME_W-1:0]  ROUND_BIAS  = 64'd5;
    localparam logic [RATIO_W-1:0] TENTHS      = 32'd10;

    // x / 5 == (x * RECIP5) >> RECIP5_SH for any 32-bit x
    localparam logic [STEP_W-1:0]  RECIP5    = 32'hCCCC_CCCD;
    localparam int                 RECIP5_SH = 34;

    localparam logic [STEP_W-1:0]  RST_STEP  = 32'd1000000;
    localparam logic [TENTH_W-1:0] RST_TENTH = 29'd100000;
    localparam logic [SHIFT_W-1:0] RST_SHIFT = 6'd17;
    localparam logic [STEP_W-1:0]  RST_POW   = 32'd131072;

    // configuration register indexes
    localparam logic REG_NUM = 1'b0;
    localparam logic REG_DEN = 1'b1;

    // request kinds
    localparam logic REQ_SYNC = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [TIME_W-1:0]    dividend;
        logic [RATIO_W-1:0]   divisor;
    } div_cmd_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [TIME_W-1:0]    quotient;
        logic [RATIO_W-1:0]   remainder;
    } div_stat_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

@@ hdl/calibrated_millisecond_counter_unit.sv @@
// Top level of the calibrated millisecond counter: sequencer, state and stream ports.
//
// Counts calibrated milliseconds from 64-bit host nanosecond timestamps. A write to
// ratio_num or ratio_den recomputes the step (host ns per calibrated ms), its rounded
// tenth and the power of two not below the tenth; s_tready stays low for that work,
// one pass of the bit-serial divider, a reciprocal multiply for the tenth and a shift
// loop. Each input beat (tuser = 0 sync, 1 tick) returns one output beat with the
// state. A sync beat and a tick that passes no boundary go from ST_TCHK straight to
// ST_TOUT; a tick that passes exactly one boundary goes through ST_TSUB and ST_TUPD,
// and a tick that passes more also waits in ST_TWAIT, since the elapsed time goes
// through the same divider to get the count of skipped milliseconds and the
// remainder. A finished result sits in an output register, so the next beat is taken
// while it waits.
module calibrated_millisecond_counter_unit
    import cmc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [RATIO_W-1:0]      cfg_data,
    // input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_DATA_W-1:0]    s_tdata,   // [63:0] now_time
    input  logic                    s_tuser,   // [0] req_type
    // output stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [31:0] ms_count, [95:32] last_boundary, [159:96] next_boundary,
    // [191:160] nsecs_per_msec, [220:192] nsecs_per_100us, [226:221] tick_shift,
    // [258:227] tick_magnitude, [263:259] zero
    output logic [OUT_DATA_W-1:0]   m_tdata
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DMUL   = 4'd1;   // ratio product
    localparam logic [3:0] ST_DSTART = 4'd2;   // start step division
    localparam logic [3:0] ST_DWAIT1 = 4'd3;
    localparam logic [3:0] ST_DTEN   = 4'd4;   // tenth by reciprocal multiply
    localparam logic [3:0] ST_DWAIT2 = 4'd5;   // take the tenth
    localparam logic [3:0] ST_DPOW   = 4'd6;   // power-of-two search
    localparam logic [3:0] ST_TCHK   = 4'd7;
    localparam logic [3:0] ST_TSUB   = 4'd8;
    localparam logic [3:0] ST_TWAIT  = 4'd9;
    localparam logic [3:0] ST_TUPD   = 4'd10;
    localparam logic [3:0] ST_TOUT   = 4'd11;

    logic [3:0]             state_reg, state_next;
    logic [RATIO_W-1:0]     num_reg, num_next;
    logic [RATIO_W-1:0]     den_reg, den_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [2*STEP_W-1:0]    tprod_reg, tprod_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [TENTH_W-1:0]     tenth_reg, tenth_next;
    logic [SHIFT_W-1:0]     shift_reg, shift_next;
    logic [STEP_W-1:0]      pow_reg, pow_next;
    logic [TIME_W-1:0]      last_reg, last_next;
    logic [TIME_W-1:0]      next_reg, next_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic                   kind_reg, kind_next;
    logic [TIME_W-1:0]      diff_reg, diff_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]  m_data_reg, m_data_next;

    logic                   ratio_zero;
    logic [RATIO_W-1:0]     num_eff;
    logic [RATIO_W-1:0]     den_eff;
    logic [TIME_W-1:0]      step64;
    logic [STEP_W:0]        tenth_sum;
    logic [STEP_W-1:0]      half_sum;
    div_cmd_t               div_cmd;
    div_stat_t              div_stat;

    assign ratio_zero = (num_reg == '0) || (den_reg == '0);
    assign num_eff    = ratio_zero ? RATIO_W'(1) : num_reg;
    assign den_eff    = ratio_zero ? RATIO_W'(1) : den_reg;
    assign step64     = {{(TIME_W-STEP_W){1'b0}}, step_reg};
    // (step + 5) / 10 == ((step + 5) / 2) / 5
    assign tenth_sum  = {1'b0, step_reg} + (STEP_W+1)'(ROUND_BIAS);
    assign half_sum   = tenth_sum[STEP_W:1];

    assign s_tready = (state_reg == ST_IDLE) && !cfg_we;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    cmc_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    always_comb
    begin
        state_next   = state_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        prod_next    = prod_reg;
        tprod_next   = tprod_reg;
        step_next    = step_reg;
        tenth_next   = tenth_reg;
        shift_next   = shift_reg;
        pow_next     = pow_reg;
        last_next    = last_reg;
        next_next    = next_reg;
        count_next   = count_reg;
        now_next     = now_reg;
        kind_next    = kind_reg;
        diff_next    = diff_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        div_cmd.start    = 1'b0;
        div_cmd.dividend = diff_reg;
        div_cmd.divisor  = step_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    now_next   = s_tdata;
                    kind_next  = s_tuser;
                    state_next = ST_TCHK;
                end
            end
            ST_DMUL:
            begin
                prod_next  = PROD_W'(NS_PER_MS20 * den_eff);
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                // round half up: add num/2 before dividing
                div_cmd.start    = 1'b1;
                div_cmd.dividend = {{(TIME_W-PROD_W){1'b0}}, prod_reg}
                                   + {{(TIME_W-RATIO_W+1){1'b0}}, num_eff[RATIO_W-1:1]};
                div_cmd.divisor  = num_eff;
                state_next       = ST_DWAIT1;
            end
            ST_DWAIT1:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.quotient[TIME_W-1:STEP_W] != '0)
                        step_next = {STEP_W{1'b1}};
                    else if (div_stat.quotient[STEP_W-1:0] == '0)
                        step_next = STEP_W'(1);
                    else
                        step_next = div_stat.quotient[STEP_W-1:0];
                    state_next = ST_DTEN;
                end
            end
            ST_DTEN:
            begin
                tprod_next = {{STEP_W{1'b0}}, half_sum} * {{STEP_W{1'b0}}, RECIP5};
                state_next = ST_DWAIT2;
            end
            ST_DWAIT2:
            begin
                tenth_next = tprod_reg[RECIP5_SH +: TENTH_W];
                pow_next   = STEP_W'(1);
                shift_next = '0;
                state_next = ST_DPOW;
            end
            ST_DPOW:
            begin
                // stops at zero when the power overflows
                if ((pow_reg != '0) && (pow_reg < {{(STEP_W-TENTH_W){1'b0}}, tenth_reg}))
                begin
                    pow_next   = {pow_reg[STEP_W-2:0], 1'b0};
                    shift_next = shift_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TCHK:
            begin
                if (kind_reg == REQ_SYNC)
                begin
                    last_next  = now_reg;
                    next_next  = sat_add(now_reg, NS_PER_MS);
                    count_next = '0;
                    state_next = ST_TOUT;
                end
                else if (now_reg < next_reg)
                begin
                    state_next = ST_TOUT;
                end
                else
                begin
                    diff_next  = now_reg - next_reg;
                    state_next = ST_TSUB;
                end
            end
            ST_TSUB:
            begin
                // common case: only the next boundary was passed
                if (diff_reg < step64)
                begin
                    last_next  = next_reg;
                    count_next = count_reg + 1'b1;
                    state_next = ST_TUPD;
                end
                else
                begin
                    div_cmd.start = 1'b1;
                    state_next    = ST_TWAIT;
                end
            end
            ST_TWAIT:
            begin
                if (div_stat.done)
                begin
                    // last boundary = now minus the part of a step past it
                    last_next  = now_reg - {{(TIME_W-RATIO_W){1'b0}}, div_stat.remainder};
                    count_next = count_reg + div_stat.quotient[COUNT_W-1:0] + 1'b1;
                    state_next = ST_TUPD;
                end
            end
            ST_TUPD:
            begin
                next_next  = sat_add(last_reg, step64);
                state_next = ST_TOUT;
            end
            ST_TOUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b0, pow_reg, shift_reg, tenth_reg, step_reg,
                                    next_reg, last_reg, count_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a write restarts the derivation
        if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM: num_next = cfg_data;
                REG_DEN: den_next = cfg_data;
                default: num_next = num_reg;
            endcase
            state_next = ST_DMUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            num_reg     <= RATIO_W'(1);
            den_reg     <= RATIO_W'(1);
            step_reg    <= RST_STEP;
            tenth_reg   <= RST_TENTH;
            shift_reg   <= RST_SHIFT;
            pow_reg     <= RST_POW;
            last_reg    <= '0;
            next_reg    <= NS_PER_MS;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            num_reg     <= num_next;
            den_reg     <= den_next;
            step_reg    <= step_next;
            tenth_reg   <= tenth_next;
            shift_reg   <= shift_next;
            pow_reg     <= pow_next;
            last_reg    <= last_next;
            next_reg    <= next_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        tprod_reg  <= tprod_next;
        now_reg    <= now_next;
        kind_reg   <= kind_next;
        diff_reg   <= diff_next;
        m_data_reg <= m_data_next;
    end

    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0)
        else $error("step is zero");

    a_edges_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (next_reg >= last_reg))
        else $error("next boundary below last boundary");

    a_pow_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> $onehot0(pow_reg))
        else $error("tick magnitude not a power of two");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("beat taken while busy");

    a_out_only_from_tout: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_valid_reg && m_valid_next) |-> (state_reg == ST_TOUT))
        else $error("result loaded outside output state");

endmodule

@@ hdl/cmc_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, shared by all users.
module cmc_divider
    import cmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_cmd_t  cmd,
    output div_stat_t stat
);

    localparam int CNT_W = $clog2(TIME_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TIME_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]   quo_reg, quo_next;
    logic [RATIO_W-1:0]  rem_reg, rem_next;
    logic [RATIO_W-1:0]  dsr_reg, dsr_next;

    logic [RATIO_W:0]    trial;
    logic [RATIO_W:0]    trial_sub;
    logic                fits;

    assign trial     = {rem_reg, quo_reg[TIME_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign fits      = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = cmd.dividend;
            rem_next  = '0;
            dsr_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[TIME_W-2:0], fits};
            rem_next = fits ? trial_sub[RATIO_W-1:0] : trial[RATIO_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for calibrated_millisecond_counter_unit: beat stimulus, scoreboard, checks.
module testbench;
    import cmc_pkg::*;

    // Output beat fields, declared MSB first so that a plain cast from m_tdata lines up:
    // ms_count sits in the lowest bits, tick_magnitude in the highest.
    typedef struct packed {
        logic [STEP_W-1:0]  tick_mag;
        logic [SHIFT_W-1:0] tick_shift;
        logic [TENTH_W-1:0] per_100us;
        logic [STEP_W-1:0]  per_msec;
        logic [TIME_W-1:0]  next_b;
        logic [TIME_W-1:0]  last_b;
        logic [COUNT_W-1:0] count;
    } ms_report_t;

    localparam int REPORT_W = $bits(ms_report_t);
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // DUT inputs start at known values
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = REG_NUM;
    logic [RATIO_W-1:0]    cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [63:0] now_time
    logic                  s_tuser   = REQ_SYNC;   // [0] req_type
    logic                  m_tready  = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_DATA_W-1:0]  m_tdata;

    always #5 clk = ~clk;

    calibrated_millisecond_counter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ---------------------------------------------------------------------------------
    // Shadow of the counter: ratio registers, derived step values and boundary state.
    // ---------------------------------------------------------------------------------
    logic [RATIO_W-1:0] sh_num   = 32'd1;
    logic [RATIO_W-1:0] sh_den   = 32'd1;
    logic [TIME_W-1:0]  sh_root  = '0;
    logic [TIME_W-1:0]  sh_last  = '0;
    logic [TIME_W-1:0]  sh_next  = NS_PER_MS;
    logic [COUNT_W-1:0] sh_count = '0;
    logic [STEP_W-1:0]  sh_step  = RST_STEP;
    logic [STEP_W-1:0]  sh_tenth = 32'd100000;
    logic [SHIFT_W-1:0] sh_shift = RST_SHIFT;
    logic [STEP_W-1:0]  sh_pow   = RST_POW;

    ms_report_t due_reports[$];   // expected output beats, oldest first
    int errors      = 0;
    int tx_idle_pct = 0;          // chance per beat that the sender inserts a gap
    int rx_idle_pct = 0;          // chance per cycle that the receiver drops tready
    int rx_hold_len = 0;          // cycles of forced receiver back-pressure left

    // ns per calibrated ms, its rounded tenth and the power of two covering the tenth
    function void recompute_step();
        logic [TIME_W-1:0]  n;
        logic [TIME_W-1:0]  d;
        logic [TIME_W-1:0]  q;
        logic [TIME_W-1:0]  t;
        logic [STEP_W-1:0]  mag;
        logic [SHIFT_W-1:0] sh;
        n = TIME_W'(sh_num);
        d = TIME_W'(sh_den);
        if (n == 0 || d == 0)
        begin
            n = 64'd1;
            d = 64'd1;
        end
        q = (NS_PER_MS * d + (n >> 1)) / n;
        if (q > 64'hFFFF_FFFF)
            q = 64'hFFFF_FFFF;
        if (q == 0)
            q = 64'd1;
        t = (q + ROUND_BIAS) / TIME_W'(TENTHS);
        sh_step  = q[STEP_W-1:0];
        sh_tenth = t[STEP_W-1:0];
        mag = 32'd1;
        sh  = '0;
        while (mag != 0 && mag < sh_tenth)
        begin
            mag = mag << 1;
            sh  = sh + 1'b1;
        end
        sh_pow   = mag;
        sh_shift = sh;
    endfunction

    // Apply one request to the shadow state and return the beat the DUT must send.
    function ms_report_t count_millis(logic kind, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] skipped;
        logic [TIME_W:0]   wide;
        ms_report_t        r;
        if (kind == REQ_SYNC)
        begin
            wide     = {1'b0, now} + {1'b0, NS_PER_MS};
            sh_root  = now;
            sh_last  = now;
            sh_next  = wide[TIME_W] ? TIME_MAX : wide[TIME_W-1:0];
            sh_count = '0;
        end
        else if (now >= sh_next)
        begin
            // whole steps passed beyond the pending boundary, all in one go
            skipped  = (now - sh_next) / TIME_W'(sh_step);
            sh_last  = sh_next + skipped * TIME_W'(sh_step);
            wide     = {1'b0, sh_last} + {1'b0, TIME_W'(sh_step)};
            sh_next  = wide[TIME_W] ? TIME_MAX : wide[TIME_W-1:0];
            sh_count = sh_count + skipped[COUNT_W-1:0] + 1'b1;
        end
        r.count      = sh_count;
        r.last_b     = sh_last;
        r.next_b     = sh_next;
        r.per_msec   = sh_step;
        r.per_100us  = sh_tenth[TENTH_W-1:0];
        r.tick_shift = sh_shift;
        r.tick_mag   = sh_pow;
        return r;
    endfunction

    // ---------------------------------------------------------------------------------
    // Receiver: random tready, or a forced hold-off counted down here.
    // ---------------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rx_hold_len > 0)
        begin
            m_tready <= 1'b0;
            rx_hold_len = rx_hold_len - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function void check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Scoreboard: every output beat against the oldest expectation.
    always @(posedge clk)
    begin
        ms_report_t want;
        ms_report_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[REPORT_W-1:0];
            if (m_tdata[OUT_DATA_W-1:REPORT_W] !== '0)
            begin
                $error("pad bits: expected 0, got %0d", m_tdata[OUT_DATA_W-1:REPORT_W]);
                errors++;
            end
            if (due_reports.size() == 0)
            begin
                $error("output beat with no request pending");
                errors++;
            end
            else
            begin
                want = due_reports.pop_front();
                check_field("ms_count",        TIME_W'(want.count),      TIME_W'(got.count));
                check_field("last_boundary",   want.last_b,              got.last_b);
                check_field("next_boundary",   want.next_b,              got.next_b);
                check_field("nsecs_per_msec",  TIME_W'(want.per_msec),   TIME_W'(got.per_msec));
                check_field("nsecs_per_100us", TIME_W'(want.per_100us),
                            TIME_W'(got.per_100us));
                check_field("tick_shift",      TIME_W'(want.tick_shift),
                            TIME_W'(got.tick_shift));
                check_field("tick_magnitude",  TIME_W'(want.tick_mag),   TIME_W'(got.tick_mag));
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Sender. Called at a rising edge; returns at the edge the beat was taken. tvalid
    // stays high between back-to-back beats and is dropped only for a gap or by drain_reports.
    // ---------------------------------------------------------------------------------
    task send_beat(logic kind, logic [TIME_W-1:0] now);
        int gap;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= now;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due_reports.push_back(count_millis(kind, now));
    endtask

    // Stop offering beats and wait for every expected beat to come back.
    task drain_reports();
        s_tvalid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge clk);
    endtask

    // Ratio write, only with the block idle. The recompute holds s_tready low; wait it out
    // before anything else touches the block.
    task write_ratio(logic idx, logic [RATIO_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_NUM)
            sh_num = value;
        else
            sh_den = value;
        recompute_step();
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task set_ratio(logic [RATIO_W-1:0] num, logic [RATIO_W-1:0] den);
        drain_reports();
        write_ratio(REG_NUM, num);
        write_ratio(REG_DEN, den);
    endtask

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    // Reset ratio 1:1: ticks below, on and past the first boundary, then a long jump.
    task test_reset_defaults();
        send_beat(REQ_TICK, 64'd0);
        send_beat(REQ_TICK, 64'd999_999);
        send_beat(REQ_TICK, 64'd1_000_000);
        send_beat(REQ_TICK, 64'd2_999_999);
        send_beat(REQ_TICK, 64'd1_000_000_000_000);
        send_beat(REQ_SYNC, {$urandom, $urandom});
    endtask

    // Saturating boundaries at the top of the time range and a count that wraps.
    task test_top_of_range();
        send_beat(REQ_SYNC, TIME_MAX);
        send_beat(REQ_TICK, TIME_MAX);
        send_beat(REQ_TICK, TIME_MAX);
        send_beat(REQ_SYNC, TIME_MAX - NS_PER_MS);
        send_beat(REQ_TICK, TIME_MAX);
        send_beat(REQ_SYNC, 64'd0);
        send_beat(REQ_TICK, TIME_MAX);
    endtask

    // Zero in either ratio register, saturated step, step clamped to one.
    task test_ratio_extremes();
        set_ratio(32'd0, 32'd5000);
        send_beat(REQ_SYNC, 64'd12345);
        send_beat(REQ_TICK, 64'd4_000_000);
        set_ratio(32'd7, 32'd0);
        send_beat(REQ_SYNC, 64'd0);
        send_beat(REQ_TICK, 64'd1_500_000);
        set_ratio(32'd1, 32'hFFFF_FFFF);
        send_beat(REQ_SYNC, {$urandom, $urandom});
        send_beat(REQ_TICK, TIME_MAX);
        set_ratio(32'hFFFF_FFFF, 32'd1);
        send_beat(REQ_SYNC, 64'd0);
        send_beat(REQ_TICK, {$urandom, $urandom});
    endtask

    // Mostly sync-then-tick runs that cross a few boundaries at a time, plus long jumps,
    // early ticks and noise. One ratio and idling mix per phase.
    task test_random_traffic();
        int               ph;
        int               roll;
        int               sel;
        logic             kind;
        logic [TIME_W-1:0] now;
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: set_ratio($urandom_range(1_010_000, 990_000), 32'd1_000_000);
                1: set_ratio($urandom, $urandom);
                default: set_ratio($urandom_range(1000, 1), $urandom_range(1000, 1));
            endcase
            tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 65 : 0;
            rx_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 33 : 0;
            repeat (190)
            begin
                roll = $urandom_range(99);
                kind = REQ_TICK;
                if (roll < 8)
                begin
                    kind = 1'($urandom_range(1, 0));
                    now  = {$urandom, $urandom};
                end
                else if (roll < 18)
                begin
                    kind = REQ_SYNC;
                    if ($urandom_range(9) == 0)
                        now = ~TIME_W'($urandom_range(3_000_000));
                    else
                        now = {$urandom, $urandom};
                end
                else
                begin
                    sel = $urandom_range(99);
                    if (sel < 20)          // just short of the pending boundary
                        now = sh_next - 64'd1 - TIME_W'($urandom_range(1000));
                    else if (sel < 65)     // one boundary
                        now = sh_next + TIME_W'($urandom_range(sh_step - 1, 0));
                    else if (sel < 88)     // a handful of boundaries
                        now = sh_next + TIME_W'($urandom_range(6, 2)) * TIME_W'(sh_step)
                              + TIME_W'($urandom_range(sh_step - 1, 0));
                    else                   // far ahead
                        now = sh_next + ({$urandom, $urandom} >> $urandom_range(63, 0));
                end
                send_beat(kind, now);
            end
        end
    endtask

    // Receiver holds off long enough for the output register to fill and s_tready to
    // drop while beats keep coming; then the sender waits for everything to drain.
    task test_output_hold();
        int k;
        drain_reports();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_len = 300;
        send_beat(REQ_SYNC, {$urandom, $urandom});
        for (k = 0; k < 12; k++)
            send_beat(REQ_TICK, sh_next + TIME_W'(k % 3) * TIME_W'(sh_step));
        drain_reports();
    endtask

    initial
    begin
        recompute_step();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct = 33;
        rx_idle_pct = 65;

        test_reset_defaults();
        test_top_of_range();
        test_ratio_extremes();
        test_random_traffic();
        test_output_hold();

        // leave room for any stray beat
        drain_reports();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: several times the slowest legal run (multi-ms ticks, stalls, recomputes).
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
